// ----- hdl/ic2d_pkg.sv -----
// ----------------------------------------------------------------------------
// ic2d_pkg
// shared types, codes and constants of the 2-d convolution unit
// ----------------------------------------------------------------------------
package ic2d_pkg;

    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_KERNEL = 64;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_DEPTH     = 4096;
    localparam int COEF_W         = 16;
    localparam int CIDX_W         = 12;
    localparam int PIX_W          = 8;
    localparam int ROWS_W         = 13;
    localparam int COLS_W         = 11;
    localparam int KSIDE_W        = 7;
    localparam int ROW_OUT_W      = 12;
    localparam int COL_OUT_W      = 10;
    localparam int ROWS_MAX       = 4096;

    localparam logic [ROWS_W-1:0]  ROWS_RST  = 13'd512;
    localparam logic [COLS_W-1:0]  COLS_RST  = 11'd512;
    localparam logic [KSIDE_W-1:0] KSIDE_RST = 7'd3;

    typedef logic [1:0] t_req;
    localparam t_req REQ_COEF  = 2'd0;
    localparam t_req REQ_PIXEL = 2'd1;
    localparam t_req REQ_DRAIN = 2'd2;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ROWS  = 2'd0;
    localparam t_reg_idx REG_COLS  = 2'd1;
    localparam t_reg_idx REG_KSIDE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_TAPS,
        ST_FLUSH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic coef_wr;
        logic pixel_wr;
        logic start;
        logic tap;
        logic load_out;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic out_ready;
        logic last_tap;
        logic pipe_empty;
    } t_stat;

endpackage

// ----- hdl/ic2d_ram.sv -----
// ----------------------------------------------------------------------------
// ic2d_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ic2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/ic2d_ctrl.sv -----
// ----------------------------------------------------------------------------
// ic2d_ctrl
// sequencer: accepts a transaction, runs the tap sweep, presents the result
// ----------------------------------------------------------------------------
module ic2d_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  ic2d_pkg::t_req    i_req,
    input  logic              i_m_tready,
    input  ic2d_pkg::t_stat   i_stat,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    output ic2d_pkg::t_cmd    o_cmd
);

    ic2d_pkg::t_state r_state, n_state;
    logic             accept;

    assign accept = (r_state == ic2d_pkg::ST_IDLE) && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ic2d_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ic2d_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req) inside
                        ic2d_pkg::REQ_PIXEL, ic2d_pkg::REQ_DRAIN: n_state = ic2d_pkg::ST_CHECK;
                        default: n_state = ic2d_pkg::ST_IDLE;
                    endcase
                end
            end
            ic2d_pkg::ST_CHECK: begin
                n_state = i_stat.out_ready ? ic2d_pkg::ST_START : ic2d_pkg::ST_IDLE;
            end
            ic2d_pkg::ST_START: n_state = ic2d_pkg::ST_TAPS;
            ic2d_pkg::ST_TAPS: begin
                if (i_stat.last_tap) begin
                    n_state = ic2d_pkg::ST_FLUSH;
                end
            end
            ic2d_pkg::ST_FLUSH: begin
                if (i_stat.pipe_empty) begin
                    n_state = ic2d_pkg::ST_OUT;
                end
            end
            ic2d_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_state = ic2d_pkg::ST_IDLE;
                end
            end
            default: n_state = ic2d_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            ic2d_pkg::ST_IDLE: begin
                o_s_tready      = 1'b1;
                o_cmd.coef_wr   = accept && (i_req == ic2d_pkg::REQ_COEF);
                o_cmd.pixel_wr  = accept && (i_req == ic2d_pkg::REQ_PIXEL);
            end
            ic2d_pkg::ST_CHECK: ;
            ic2d_pkg::ST_START: o_cmd.start = 1'b1;
            ic2d_pkg::ST_TAPS:  o_cmd.tap = 1'b1;
            ic2d_pkg::ST_FLUSH: o_cmd.load_out = i_stat.pipe_empty;
            ic2d_pkg::ST_OUT: begin
                o_m_tvalid    = 1'b1;
                o_cmd.advance = i_m_tready;
            end
            default: ;
        endcase
    end

endmodule

// ----- hdl/ic2d_datapath.sv -----
// ----------------------------------------------------------------------------
// ic2d_datapath
// positions, line and coefficient stores, tap address walk and accumulator
// ----------------------------------------------------------------------------
module ic2d_datapath #(
    parameter int MAX_COLS   = ic2d_pkg::DEF_MAX_COLS,
    parameter int MAX_KERNEL = ic2d_pkg::DEF_MAX_KERNEL
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ic2d_pkg::ROWS_W-1:0]       i_rows,
    input  logic [ic2d_pkg::COLS_W-1:0]       i_cols,
    input  logic [ic2d_pkg::KSIDE_W-1:0]      i_kside,
    input  logic                              i_restart,
    input  ic2d_pkg::t_cmd                    i_cmd,
    input  logic [ic2d_pkg::CIDX_W-1:0]       i_coef_index,
    input  logic [ic2d_pkg::COEF_W-1:0]       i_coef_value,
    input  logic [ic2d_pkg::PIX_W-1:0]        i_pixel,
    output ic2d_pkg::t_stat                   o_stat,
    output logic [ic2d_pkg::PIX_W-1:0]        o_pixel,
    output logic [ic2d_pkg::ROW_OUT_W-1:0]    o_row,
    output logic [ic2d_pkg::COL_OUT_W-1:0]    o_col,
    output logic                              o_last
);

    localparam int DEPTH  = MAX_COLS * MAX_KERNEL;
    localparam int AW     = $clog2(DEPTH);
    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int PROD_W = ic2d_pkg::PIX_W + ic2d_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + 2 * $clog2(MAX_KERNEL) + 1;
    localparam int HC_W   = KW + ic2d_pkg::COLS_W;

    function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + (AW+1)'(DEPTH) - {1'b0, b};
        end
        return s[AW-1:0];
    endfunction

    // clamped geometry
    logic [ic2d_pkg::ROWS_W-1:0] rows_c;
    logic [ic2d_pkg::COLS_W-1:0] cols_c;
    logic [KW-1:0]               k_c, half, after;

    always_comb begin
        if (i_rows == '0) begin
            rows_c = ic2d_pkg::ROWS_W'(1);
        end else if (i_rows > ic2d_pkg::ROWS_W'(ic2d_pkg::ROWS_MAX)) begin
            rows_c = ic2d_pkg::ROWS_W'(ic2d_pkg::ROWS_MAX);
        end else begin
            rows_c = i_rows;
        end
        if (i_cols == '0) begin
            cols_c = ic2d_pkg::COLS_W'(1);
        end else if (32'(i_cols) > 32'(MAX_COLS)) begin
            cols_c = ic2d_pkg::COLS_W'(MAX_COLS);
        end else begin
            cols_c = i_cols;
        end
        if (i_kside == '0) begin
            k_c = KW'(1);
        end else if (32'(i_kside) > 32'(MAX_KERNEL)) begin
            k_c = KW'(MAX_KERNEL);
        end else begin
            k_c = KW'(i_kside);
        end
        half  = k_c >> 1;
        after = k_c - KW'(1) - half;
    end

    // positions
    logic [ic2d_pkg::ROWS_W-1:0]    r_in_row;
    logic [ic2d_pkg::COLS_W-1:0]    r_in_col;
    logic [AW-1:0]                  r_wr_addr;
    logic [ic2d_pkg::ROW_OUT_W-1:0] r_i;
    logic [ic2d_pkg::COLS_W-1:0]    r_j;
    logic [AW-1:0]                  r_base;
    logic [AW-1:0]                  r_half_cols, r_a1, r_start;
    logic                           pix_wr, out_last;

    assign pix_wr   = i_cmd.pixel_wr && (r_in_row < rows_c);
    assign out_last = (ic2d_pkg::ROWS_W'(r_i) == rows_c - ic2d_pkg::ROWS_W'(1))
                      && (r_j == cols_c - ic2d_pkg::COLS_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || (i_cmd.advance && out_last)) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_wr_addr <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_base    <= '0;
        end else begin
            if (pix_wr) begin
                r_wr_addr <= add_mod(r_wr_addr, AW'(1));
                if (r_in_col == cols_c - ic2d_pkg::COLS_W'(1)) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ic2d_pkg::ROWS_W'(1);
                end else begin
                    r_in_col <= r_in_col + ic2d_pkg::COLS_W'(1);
                end
            end
            if (i_cmd.advance) begin
                if (r_j == cols_c - ic2d_pkg::COLS_W'(1)) begin
                    r_j    <= '0;
                    r_i    <= r_i + ic2d_pkg::ROW_OUT_W'(1);
                    r_base <= add_mod(r_base, AW'(cols_c));
                end else begin
                    r_j <= r_j + ic2d_pkg::COLS_W'(1);
                end
            end
        end
    end

    // window start address, refreshed every cycle from settled positions
    logic [HC_W-1:0] half_cols;
    assign half_cols = HC_W'(half) * HC_W'(cols_c);

    always_ff @(posedge i_clk) begin
        r_half_cols <= AW'(half_cols);
        r_a1        <= sub_mod(r_base, r_half_cols);
        r_start     <= sub_mod(add_mod(r_a1, AW'(r_j)), AW'(half));
    end

    // readiness: last needed input pixel already received
    logic [ic2d_pkg::ROWS_W:0]   lr_sum;
    logic [ic2d_pkg::ROWS_W-1:0] lr;
    logic [ic2d_pkg::COLS_W:0]   lc_sum, lc;

    always_comb begin
        lr_sum = (ic2d_pkg::ROWS_W+1)'(r_i) + (ic2d_pkg::ROWS_W+1)'(after);
        if (lr_sum > (ic2d_pkg::ROWS_W+1)'(rows_c - ic2d_pkg::ROWS_W'(1))) begin
            lr = rows_c - ic2d_pkg::ROWS_W'(1);
        end else begin
            lr = lr_sum[ic2d_pkg::ROWS_W-1:0];
        end
        lc_sum = (ic2d_pkg::COLS_W+1)'(r_j) + (ic2d_pkg::COLS_W+1)'(after);
        if (lc_sum > (ic2d_pkg::COLS_W+1)'(cols_c - ic2d_pkg::COLS_W'(1))) begin
            lc = (ic2d_pkg::COLS_W+1)'(cols_c - ic2d_pkg::COLS_W'(1));
        end else begin
            lc = lc_sum;
        end
    end

    assign o_stat.out_ready = (r_in_row > lr)
                              || ((r_in_row == lr) && ({1'b0, r_in_col} > lc));

    // tap walk
    logic [13:0]                 r_x;
    logic [12:0]                 r_y;
    logic [KW-1:0]               r_n, r_m;
    logic [AW-1:0]               r_row_addr, r_addr;
    logic [ic2d_pkg::CIDX_W-1:0] r_cidx;
    logic                        tap_ok, last_col;

    assign tap_ok   = !r_x[13] && (r_x[12:0] < rows_c)
                      && !r_y[12] && (r_y[11:0] < {1'b0, cols_c});
    assign last_col = (r_n == k_c - KW'(1));
    assign o_stat.last_tap = last_col && (r_m == k_c - KW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x        <= 14'(r_i) - 14'(half);
            r_y        <= 13'(r_j) - 13'(half);
            r_n        <= '0;
            r_m        <= '0;
            r_row_addr <= r_start;
            r_addr     <= r_start;
            r_cidx     <= '0;
        end else if (i_cmd.tap) begin
            r_cidx <= r_cidx + ic2d_pkg::CIDX_W'(1);
            if (last_col) begin
                r_n        <= '0;
                r_m        <= r_m + KW'(1);
                r_x        <= r_x + 14'd1;
                r_y        <= 13'(r_j) - 13'(half);
                r_row_addr <= add_mod(r_row_addr, AW'(cols_c));
                r_addr     <= add_mod(r_row_addr, AW'(cols_c));
            end else begin
                r_n    <= r_n + KW'(1);
                r_y    <= r_y + 13'd1;
                r_addr <= add_mod(r_addr, AW'(1));
            end
        end
    end

    // stores
    logic [ic2d_pkg::PIX_W-1:0]  rd_pix;
    logic [ic2d_pkg::COEF_W-1:0] rd_coef;

    ic2d_ram #(
        .WIDTH (ic2d_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pix_wr),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (i_pixel),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_pix)
    );

    ic2d_ram #(
        .WIDTH (ic2d_pkg::COEF_W),
        .DEPTH (ic2d_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.coef_wr),
        .i_wr_addr (i_coef_index),
        .i_wr_data (i_coef_value),
        .i_rd_addr (r_cidx),
        .o_rd_data (rd_coef)
    );

    // multiply and accumulate
    logic              r_v1, r_v2;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap && tap_ok;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(rd_pix) * PROD_W'(rd_coef);
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_stat.pipe_empty = !r_v1 && !r_v2;

    // result register
    logic [ACC_W-1:0]           scaled;
    logic [ic2d_pkg::PIX_W-1:0] r_pix;
    logic [ic2d_pkg::ROW_OUT_W-1:0] r_orow;
    logic [ic2d_pkg::COL_OUT_W-1:0] r_ocol;
    logic                       r_olast;

    assign scaled = r_acc >> ic2d_pkg::COEF_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_pix   <= (scaled > ACC_W'(255)) ? 8'd255 : scaled[ic2d_pkg::PIX_W-1:0];
            r_orow  <= r_i;
            r_ocol  <= r_j[ic2d_pkg::COL_OUT_W-1:0];
            r_olast <= out_last;
        end
    end

    assign o_pixel = r_pix;
    assign o_row   = r_orow;
    assign o_col   = r_ocol;
    assign o_last  = r_olast;

endmodule

// ----- hdl/image_convolution_2d_unit.sv -----
// ----------------------------------------------------------------------------
// image_convolution_2d_unit
// zero padded 2-d convolution of a raster image with a square kernel
// ----------------------------------------------------------------------------
// coefficient write is completed in idle; pixel or drain without a ready output
// returns to idle from the check state; pixel or drain that emits passes start,
// taps and flush before o_m_tvalid and waits in out for the receiver; one tap per
// cycle through the line store read port, one transaction in flight at a time
// synchronous active-low reset clears control and positions and loads the
// register defaults; line and coefficient stores are not cleared
module image_convolution_2d_unit #(
    parameter int MAX_COLS   = ic2d_pkg::DEF_MAX_COLS,
    parameter int MAX_KERNEL = ic2d_pkg::DEF_MAX_KERNEL
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // coef_index[11:0], coef_value[27:12], pixel_in[35:28]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // pixel_out[7:0], out_row[19:8], out_col[29:20]
    output logic        o_m_tlast,   // frame_last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [ic2d_pkg::ROWS_W-1:0]  r_rows;
    logic [ic2d_pkg::COLS_W-1:0]  r_cols;
    logic [ic2d_pkg::KSIDE_W-1:0] r_kside;
    logic                         cfg_wr, restart;
    ic2d_pkg::t_reg_idx           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    // any write to a known register restarts the frame
    always_comb begin
        restart = 1'b0;
        if (cfg_wr) begin
            unique case (reg_idx)
                ic2d_pkg::REG_ROWS, ic2d_pkg::REG_COLS, ic2d_pkg::REG_KSIDE: restart = 1'b1;
                default: restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= ic2d_pkg::ROWS_RST;
            r_cols  <= ic2d_pkg::COLS_RST;
            r_kside <= ic2d_pkg::KSIDE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ic2d_pkg::REG_ROWS:  r_rows  <= pwdata[ic2d_pkg::ROWS_W-1:0];
                ic2d_pkg::REG_COLS:  r_cols  <= pwdata[ic2d_pkg::COLS_W-1:0];
                ic2d_pkg::REG_KSIDE: r_kside <= pwdata[ic2d_pkg::KSIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ic2d_pkg::REG_ROWS:  prdata = 32'(r_rows);
            ic2d_pkg::REG_COLS:  prdata = 32'(r_cols);
            ic2d_pkg::REG_KSIDE: prdata = 32'(r_kside);
            default:             prdata = '0;
        endcase
    end

    // controller and datapath
    ic2d_pkg::t_cmd  cmd;
    ic2d_pkg::t_stat stat;
    logic [ic2d_pkg::PIX_W-1:0]     pix_out;
    logic [ic2d_pkg::ROW_OUT_W-1:0] row_out;
    logic [ic2d_pkg::COL_OUT_W-1:0] col_out;

    ic2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req      (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    ic2d_datapath #(
        .MAX_COLS   (MAX_COLS),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rows       (r_rows),
        .i_cols       (r_cols),
        .i_kside      (r_kside),
        .i_restart    (restart),
        .i_cmd        (cmd),
        .i_coef_index (i_s_tdata[11:0]),
        .i_coef_value (i_s_tdata[27:12]),
        .i_pixel      (i_s_tdata[35:28]),
        .o_stat       (stat),
        .o_pixel      (pix_out),
        .o_row        (row_out),
        .o_col        (col_out),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, col_out, row_out, pix_out};

endmodule
